// ===== hdl/rtdf_pkg.sv =====
// Shared constants and types for the RTD code to Fahrenheit converter.
package rtdf_pkg;

  localparam int CODE_W = 15;
  localparam int RES_W  = 17;
  localparam int TEMP_W = 16;
  localparam int DISC_W = 46;
  localparam int PROD_W = 45;
  localparam int RAD_W  = 56;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int NUM_W  = 30;
  localparam int X_W    = NUM_W - 6;
  localparam int RCP_W  = 26;
  localparam int QE_W   = X_W + RCP_W - 32;

  localparam logic [DISC_W-1:0] DISC_BASE  = 46'd57621901770752;
  localparam logic [29:0]       DISC_SLOPE = 30'd993300000;
  localparam logic [8:0]        R_REF      = 9'd430;
  localparam logic [NUM_W-1:0]  NUM_BASE   = 30'd581337504;
  localparam logic [RCP_W-1:0]  RECIP_77   = 26'd55778796;
  localparam logic [6:0]        DIV_77     = 7'd77;
  localparam logic [TEMP_W-1:0] TEMP_BIAS  = 16'd20000;

  typedef struct packed {
    logic              vld;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RES_W-1:0]  res;
  } sqrt_stage_t;

  typedef struct packed {
    logic              vld;
    logic [RES_W-1:0]  res;
    logic [TEMP_W-1:0] temp;
  } temp_result_t;

endpackage

// ===== hdl/rtdf_sqrt_cell.sv =====
// One cell of the pipelined square root: resolves a single root bit per cycle.
module rtdf_sqrt_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rtdf_pkg::sqrt_stage_t stage_in,
  output rtdf_pkg::sqrt_stage_t stage_out
);

  logic [rtdf_pkg::REM_W+1:0] trial;
  logic [rtdf_pkg::REM_W+1:0] cand;
  rtdf_pkg::sqrt_stage_t      stage_nxt;
  rtdf_pkg::sqrt_stage_t      stage_r;

  assign trial = {stage_in.rem, stage_in.rad[rtdf_pkg::RAD_W-1 -: 2]};
  assign cand  = (rtdf_pkg::REM_W+2)'({stage_in.root, 2'b01});

  always_comb begin
    stage_nxt     = stage_in;
    stage_nxt.rad = {stage_in.rad[rtdf_pkg::RAD_W-3:0], 2'b00};
    if (trial >= cand) begin
      stage_nxt.rem  = rtdf_pkg::REM_W'(trial - cand);
      stage_nxt.root = {stage_in.root[rtdf_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      stage_nxt.rem  = trial[rtdf_pkg::REM_W-1:0];
      stage_nxt.root = {stage_in.root[rtdf_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    stage_r.rad  <= stage_nxt.rad;
    stage_r.rem  <= stage_nxt.rem;
    stage_r.root <= stage_nxt.root;
    stage_r.res  <= stage_nxt.res;
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else begin
      stage_r.vld <= stage_nxt.vld;
    end
  end

  assign stage_out = stage_r;

  // The partial remainder never exceeds twice the partial root.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stage_r.vld |-> ({1'b0, stage_r.rem} <= {stage_r.root, 1'b0}))
    else $error("square root remainder out of bound");

endmodule

// ===== hdl/rtdf_temp_scale.sv =====
// Turns the square root into Fahrenheit Q4 with a reciprocal divide by 4928.
module rtdf_temp_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rtdf_pkg::sqrt_stage_t         root_in,
  output rtdf_pkg::temp_result_t        result
);

  logic [rtdf_pkg::NUM_W-1:0]  num;
  logic                        vld1_r;
  logic [rtdf_pkg::RES_W-1:0]  res1_r;
  logic [rtdf_pkg::X_W-1:0]    x1_r;
  logic                        vld2_r;
  logic [rtdf_pkg::RES_W-1:0]  res2_r;
  logic [rtdf_pkg::X_W-1:0]    x2_r;
  logic [rtdf_pkg::QE_W-1:0]   qe2_r;
  logic [rtdf_pkg::X_W+rtdf_pkg::RCP_W-1:0] prod;
  logic [rtdf_pkg::X_W-1:0]    qm;
  logic [rtdf_pkg::X_W-1:0]    rmd;
  logic [rtdf_pkg::QE_W-1:0]   quot;
  rtdf_pkg::temp_result_t      result_nxt;
  rtdf_pkg::temp_result_t      result_r;

  // Dividing by 4928 is a shift by six and then a divide by 77.
  assign num  = rtdf_pkg::NUM_BASE
              - rtdf_pkg::NUM_W'(rtdf_pkg::NUM_W'(root_in.root) * rtdf_pkg::NUM_W'(3));
  assign prod = (rtdf_pkg::X_W + rtdf_pkg::RCP_W)'(x1_r)
              * (rtdf_pkg::X_W + rtdf_pkg::RCP_W)'(rtdf_pkg::RECIP_77);

  // The reciprocal estimate is low by at most one.
  assign qm   = rtdf_pkg::X_W'(rtdf_pkg::X_W'(qe2_r) * rtdf_pkg::X_W'(rtdf_pkg::DIV_77));
  assign rmd  = x2_r - qm;
  assign quot = (rmd >= rtdf_pkg::X_W'(rtdf_pkg::DIV_77)) ? qe2_r + 1'b1 : qe2_r;

  always_comb begin
    result_nxt.vld  = vld2_r;
    result_nxt.res  = res2_r;
    result_nxt.temp = quot[rtdf_pkg::TEMP_W-1:0] - rtdf_pkg::TEMP_BIAS;
  end

  always_ff @(posedge clk) begin
    x1_r          <= num[rtdf_pkg::NUM_W-1:6];
    res1_r        <= root_in.res;
    x2_r          <= x1_r;
    res2_r        <= res1_r;
    qe2_r         <= prod[rtdf_pkg::X_W+rtdf_pkg::RCP_W-1:32];
    result_r.res  <= result_nxt.res;
    result_r.temp <= result_nxt.temp;
    if (!rst_n) begin
      vld1_r       <= 1'b0;
      vld2_r       <= 1'b0;
      result_r.vld <= 1'b0;
    end else begin
      vld1_r       <= root_in.vld;
      vld2_r       <= vld1_r;
      result_r.vld <= result_nxt.vld;
    end
  end

  assign result = result_r;

  a_rmd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld2_r |-> (rmd < rtdf_pkg::X_W'(2 * 77)))
    else $error("quotient estimate off by more than one");

endmodule

// ===== hdl/rtd_code_to_fahrenheit.sv =====
// Top level: RTD converter bytes to resistance (Q8 ohms) and temperature (Q4 Fahrenheit).
//
//   channel  ports                                   direction  handshake
//   request  start, busy, in_msb_byte, in_lsb_byte   in         start && !busy
//   result   out_valid, out_resistance_q8,           out        one-cycle strobe
//            out_temp_f_q4
//
// A request is taken in every cycle; busy stays low.
// Each result passes through the 28 cells of the square root chain plus three
// front and three back stages.
// Synchronous reset clears only the valid bits of the pipeline.
// The receiver cannot stall, so nothing is ever held back.
module rtd_code_to_fahrenheit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         in_msb_byte,
  input  logic [7:0]         in_lsb_byte,
  output logic               out_valid,
  output logic [16:0]        out_resistance_q8,
  output logic signed [15:0] out_temp_f_q4
);

  logic                          vld1_r;
  logic [rtdf_pkg::CODE_W-1:0]   code_r;
  logic                          vld2_r;
  logic [rtdf_pkg::PROD_W-1:0]   prod_r;
  logic [rtdf_pkg::RES_W-1:0]    res2_r;
  logic [rtdf_pkg::PROD_W-1:0]   prod_nxt;
  logic [rtdf_pkg::RES_W-1:0]    res_nxt;
  logic [23:0]                   res_raw;
  logic [rtdf_pkg::DISC_W-1:0]   disc;
  rtdf_pkg::sqrt_stage_t         head_nxt;
  rtdf_pkg::sqrt_stage_t         head_r;
  rtdf_pkg::sqrt_stage_t         chain [0:rtdf_pkg::ROOT_W];
  rtdf_pkg::temp_result_t        result;

  assign busy = 1'b0;

  assign prod_nxt = rtdf_pkg::PROD_W'(code_r) * rtdf_pkg::PROD_W'(rtdf_pkg::DISC_SLOPE);
  assign res_raw  = 24'(code_r) * 24'(rtdf_pkg::R_REF) + 24'd64;
  assign res_nxt  = res_raw[23:7];

  assign disc = rtdf_pkg::DISC_BASE - rtdf_pkg::DISC_W'(prod_r);

  always_comb begin
    head_nxt.vld  = vld2_r;
    head_nxt.rad  = rtdf_pkg::RAD_W'({disc, 9'b0});
    head_nxt.rem  = '0;
    head_nxt.root = '0;
    head_nxt.res  = res2_r;
  end

  always_ff @(posedge clk) begin
    code_r      <= {in_msb_byte, in_lsb_byte[7:1]};
    prod_r      <= prod_nxt;
    res2_r      <= res_nxt;
    head_r.rad  <= head_nxt.rad;
    head_r.rem  <= head_nxt.rem;
    head_r.root <= head_nxt.root;
    head_r.res  <= head_nxt.res;
    if (!rst_n) begin
      vld1_r     <= 1'b0;
      vld2_r     <= 1'b0;
      head_r.vld <= 1'b0;
    end else begin
      vld1_r     <= start && !busy;
      vld2_r     <= vld1_r;
      head_r.vld <= head_nxt.vld;
    end
  end

  assign chain[0] = head_r;

  for (genvar i = 0; i < rtdf_pkg::ROOT_W; i++) begin : g_cell
    rtdf_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .stage_in (chain[i]),
      .stage_out(chain[i+1])
    );
  end

  rtdf_temp_scale u_temp (
    .clk    (clk),
    .rst_n  (rst_n),
    .root_in(chain[rtdf_pkg::ROOT_W]),
    .result (result)
  );

  assign out_valid         = result.vld;
  assign out_resistance_q8 = result.res;
  assign out_temp_f_q4     = $signed(result.temp);

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temp_f_q4 >= -16'sd6720 && out_temp_f_q4 <= 16'sd29120))
    else $error("temperature outside sensor range");

  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_resistance_q8 <= 17'd110080))
    else $error("resistance outside code range");

  a_front_flow: assert property (@(posedge clk) disable iff (!rst_n)
    vld1_r |=> vld2_r)
    else $error("request lost in front stages");

endmodule
